// ===== rtl/rkgf_pkg.sv =====
// rkgf_pkg: shared types and constants for the red-keep grayscale filter
// no dependencies; imported by every module of the block
`default_nettype none

package rkgf_pkg;

   // luma weights in 1/256 units
   localparam logic [7:0] RED_WEIGHT   = 8'd54;
   localparam logic [7:0] GREEN_WEIGHT = 8'd183;
   localparam logic [7:0] BLUE_WEIGHT  = 8'd18;

   localparam logic [7:0] HEADER_WORDS_RESET = 8'd18;
   localparam logic [7:0] COUNT_MAX          = 8'd255;

   // csr port geometry and register indexes
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic        REG_HEADER_WORDS = 1'b0;

   typedef logic [31:0] pixel_type;

   typedef struct packed {
      pixel_type upper;
      pixel_type lower;
      logic      last;
   } beat_type;

endpackage

`default_nettype wire

// ===== rtl/rkgf_req_if.sv =====
// rkgf_req_if: input beat channel, two ARGB pixels and an end-of-frame flag
// depends on rkgf_pkg for the pixel type
`default_nettype none

interface rkgf_req_if;
   import rkgf_pkg::*;

   logic      valid;
   logic      ready;
   pixel_type upper_pixel;
   pixel_type lower_pixel;
   logic      frame_end;

   modport source (output valid, upper_pixel, lower_pixel, frame_end, input ready);
   modport sink   (input valid, upper_pixel, lower_pixel, frame_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/rkgf_rsp_if.sv =====
// rkgf_rsp_if: result beat channel, two filtered ARGB pixels and end flag
// depends on rkgf_pkg for the pixel type
`default_nettype none

interface rkgf_rsp_if;
   import rkgf_pkg::*;

   logic      valid;
   logic      ready;
   pixel_type upper_result;
   pixel_type lower_result;
   logic      result_end;

   modport source (output valid, upper_result, lower_result, result_end, input ready);
   modport sink   (input valid, upper_result, lower_result, result_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/rkgf_csr.sv =====
// rkgf_csr: apb-style register port holding header_words
// depends on rkgf_pkg for address width and register indexes
`default_nettype none

module rkgf_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [rkgf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [rkgf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [rkgf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready,
   output logic      [7:0]                      header_words
);
   import rkgf_pkg::*;

   logic [7:0] header_words_ff;
   logic [7:0] header_words_in;
   logic       wr_hit;

   assign csr_pready = 1'b1;

   // register index is the word address; anything above index 0 misses
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == REG_HEADER_WORDS);

   always_comb begin
      header_words_in = header_words_ff;
      if (wr_hit) begin
         header_words_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_words_ff <= HEADER_WORDS_RESET;
      end else begin
         header_words_ff <= header_words_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[2])
         REG_HEADER_WORDS: csr_prdata = {{(CSR_DATA_W-8){1'b0}}, header_words_ff};
         default:          csr_prdata = '0;
      endcase
   end

   assign header_words = header_words_ff;

endmodule

`default_nettype wire

// ===== rtl/rkgf_pixel.sv =====
// rkgf_pixel: grayscale conversion of one ARGB pixel, red-dominant pixels kept
// depends on rkgf_pkg for the luma weights
`default_nettype none

module rkgf_pixel (
   input  wire logic                 filter_en,
   input  wire rkgf_pkg::pixel_type  pixel_in,
   output rkgf_pkg::pixel_type       pixel_out
);
   import rkgf_pkg::*;

   logic [7:0]  alpha, red, green, blue;
   logic [15:0] red_prod, green_prod, blue_prod;
   logic [8:0]  gray_sum;
   logic [7:0]  gray;
   logic        to_gray;

   assign alpha = pixel_in[31:24];
   assign red   = pixel_in[23:16];
   assign green = pixel_in[15:8];
   assign blue  = pixel_in[7:0];

   assign red_prod   = red   * RED_WEIGHT;
   assign green_prod = green * GREEN_WEIGHT;
   assign blue_prod  = blue  * BLUE_WEIGHT;

   // each product truncated on its own before the sum
   assign gray_sum = {1'b0, red_prod[15:8]} + {1'b0, green_prod[15:8]}
                     + {1'b0, blue_prod[15:8]};
   assign gray     = gray_sum[7:0];

   assign to_gray = filter_en && ((red < green) || (red < blue));

   assign pixel_out = to_gray ? {alpha, gray, gray, gray} : pixel_in;

endmodule

`default_nettype wire

// ===== rtl/red_keep_grayscale_filter_unit.sv =====
// red_keep_grayscale_filter_unit: top level, input register, pixel filters, result register
// depends on rkgf_pkg, rkgf_req_if, rkgf_rsp_if, rkgf_csr and rkgf_pixel
// a beat accepted into the input register passes the pixel filters into the result register, which drives rsp_bus
// throughput: one beat per cycle, the two-stage valid/ready pipeline fills under stall
// the header check is taken at acceptance against the 8-bit saturating word counter
// reset: synchronous, clears stage valids and the word counter, header_words back to 18
`default_nettype none

module red_keep_grayscale_filter_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   rkgf_req_if.sink                             req_bus,
   rkgf_rsp_if.source                           rsp_bus,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [rkgf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [rkgf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [rkgf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready
);
   import rkgf_pkg::*;

   logic [7:0] header_words;

   logic       req_accept, rsp_accept, s1_advance;

   logic [7:0] word_count_ff, word_count_in;
   logic       s1_valid_ff, s1_valid_in;
   beat_type   s1_beat_ff, s1_beat_in;
   logic       s1_filter_ff, s1_filter_in;
   logic       rsp_valid_ff, rsp_valid_in;
   beat_type   rsp_beat_ff, rsp_beat_in;
   pixel_type  upper_filt, lower_filt;

   rkgf_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .header_words (header_words)
   );

   assign s1_advance    = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_advance;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign rsp_accept    = rsp_valid_ff && rsp_bus.ready;

   // word counter, saturating, cleared after the last beat of a frame
   always_comb begin
      word_count_in = word_count_ff;
      if (req_accept) begin
         if (req_bus.frame_end) begin
            word_count_in = '0;
         end else if (word_count_ff != COUNT_MAX) begin
            word_count_in = word_count_ff + 8'd1;
         end
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_beat_in   = s1_beat_ff;
      s1_filter_in = s1_filter_ff;
      if (req_accept) begin
         s1_valid_in  = 1'b1;
         s1_beat_in   = '{upper: req_bus.upper_pixel, lower: req_bus.lower_pixel,
                          last: req_bus.frame_end};
         s1_filter_in = (word_count_ff >= header_words);
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   rkgf_pixel u_upper (
      .filter_en (s1_filter_ff),
      .pixel_in  (s1_beat_ff.upper),
      .pixel_out (upper_filt)
   );

   rkgf_pixel u_lower (
      .filter_en (s1_filter_ff),
      .pixel_in  (s1_beat_ff.lower),
      .pixel_out (lower_filt)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
         rsp_beat_in  = '{upper: upper_filt, lower: lower_filt, last: s1_beat_ff.last};
      end else if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_count_ff <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         word_count_ff <= word_count_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_beat_ff   <= s1_beat_in;
      s1_filter_ff <= s1_filter_in;
      rsp_beat_ff  <= rsp_beat_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.upper_result = rsp_beat_ff.upper;
   assign rsp_bus.lower_result = rsp_beat_ff.lower;
   assign rsp_bus.result_end   = rsp_beat_ff.last;

   a_count_clear: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_bus.frame_end) |=> (word_count_ff == 8'd0))
      else $error("word counter not cleared after last beat");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_bus.frame_end && (word_count_ff != COUNT_MAX))
      |=> (word_count_ff == $past(word_count_ff) + 8'd1))
      else $error("word counter did not advance");

   a_filter_flag: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (s1_filter_ff == ($past(word_count_ff) >= $past(header_words))))
      else $error("header check captured wrong");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(s1_beat_ff)))
      else $error("stalled input stage lost its beat");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |-> !s1_advance)
      else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
